[sv/kvlt_pkg.sv]
// ----------------------------------------------------------------------------
// kvlt_pkg
// Shared types and constants for the key/value line tokenizer.
// ----------------------------------------------------------------------------
package kvlt_pkg;

   localparam int SLOT_LIMIT = 16;
   localparam int SLOT_W     = $clog2(SLOT_LIMIT + 1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_DIG0  = 8'h30;
   localparam logic [7:0] CH_DIG9  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_EQ    = 8'h3d;

   localparam logic [7:0] MID_WORD [3] = '{8'h6d, 8'h69, 8'h64};

   localparam logic [2:0] MID_FULL = 3'd3;
   localparam logic [2:0] MID_MISS = 3'd4;

   localparam logic [1:0] ROLE_SEP = 2'd0;
   localparam logic [1:0] ROLE_KEY = 2'd1;
   localparam logic [1:0] ROLE_VAL = 2'd2;

   localparam logic [1:0] DPH_LEAD = 2'd0;
   localparam logic [1:0] DPH_DIG  = 2'd1;
   localparam logic [1:0] DPH_STOP = 2'd2;

   typedef enum logic [2:0] {
      PH_BETWEEN,
      PH_KEY,
      PH_AFTER_EQ,
      PH_QOPEN,
      PH_VAL,
      PH_QVAL,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic       zero;
      logic       space;
      logic       eq;
      logic       quote;
      logic       semi;
      logic       ws;
      logic       plus;
      logic       minus;
      logic       digit;
      logic [3:0] dval;
      logic [2:0] mid_hit;
   } cls_type;

   typedef struct packed {
      logic    valid;
      cls_type cls;
   } link_type;

   typedef struct packed {
      logic [1:0]         role;
      logic [3:0]         slot;
      logic               token_start;
      logic               retract;
      logic               line_done;
      logic               parse_error;
      logic [3:0]         param_count;
      logic signed [31:0] message_id;
   } rsp_type;

endpackage

[sv/key_value_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// key_value_line_tokenizer
// Splits a zero-terminated command line into key and key=value tokens.
// ----------------------------------------------------------------------------
// One character is taken per clock while the input queue is not full and one
// result is produced for each character, so a steady stream runs at one
// transaction per cycle unless a queue fills. A character passes a classifier
// and a two-entry queue, then the token state machine, which writes its
// result into a two-entry result queue; the result is registered in both
// queues before it appears on the rsp_ ports. Either side may stall without
// stopping the other until a queue fills. A mid=<n> option is removed from
// the token stream and its decimal value is reported on rsp_message_id;
// after an error, bytes up to the zero byte are separators with parse error.
module key_value_line_tokenizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_ch,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_role,
   output logic [3:0]         rsp_slot,
   output logic               rsp_token_start,
   output logic               rsp_retract,
   output logic               rsp_line_done,
   output logic               rsp_parse_error,
   output logic [3:0]         rsp_param_count,
   output logic signed [31:0] rsp_message_id
);

   kvlt_pkg::link_type link;
   logic               link_pop;
   kvlt_pkg::rsp_type  rsp;

   kvlt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_ch   (req_ch),
      .req_full (req_full),
      .link     (link),
      .link_pop (link_pop)
   );

   kvlt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .link      (link),
      .link_pop  (link_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_role        = rsp.role;
   assign rsp_slot        = rsp.slot;
   assign rsp_token_start = rsp.token_start;
   assign rsp_retract     = rsp.retract;
   assign rsp_line_done   = rsp.line_done;
   assign rsp_parse_error = rsp.parse_error;
   assign rsp_param_count = rsp.param_count;
   assign rsp_message_id  = rsp.message_id;

endmodule

[sv/kvlt_front.sv]
// ----------------------------------------------------------------------------
// kvlt_front
// Character classifier with a two-entry queue towards the token engine.
// ----------------------------------------------------------------------------
module kvlt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_ch,
   output logic               req_full,
   output kvlt_pkg::link_type link,
   input  logic               link_pop
);

   kvlt_pkg::cls_type cls_in;
   kvlt_pkg::cls_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push_ok, pop_ok;

   always_comb begin
      cls_in.zero    = (req_ch == kvlt_pkg::CH_NUL);
      cls_in.space   = (req_ch == kvlt_pkg::CH_SPACE);
      cls_in.eq      = (req_ch == kvlt_pkg::CH_EQ);
      cls_in.quote   = (req_ch == kvlt_pkg::CH_QUOTE);
      cls_in.semi    = (req_ch == kvlt_pkg::CH_SEMI);
      cls_in.ws      = (req_ch == kvlt_pkg::CH_SPACE) ||
                       ((req_ch >= kvlt_pkg::CH_TAB) && (req_ch <= kvlt_pkg::CH_CR));
      cls_in.plus    = (req_ch == kvlt_pkg::CH_PLUS);
      cls_in.minus   = (req_ch == kvlt_pkg::CH_MINUS);
      cls_in.digit   = (req_ch >= kvlt_pkg::CH_DIG0) && (req_ch <= kvlt_pkg::CH_DIG9);
      cls_in.dval    = req_ch[3:0];
      cls_in.mid_hit = {req_ch == kvlt_pkg::MID_WORD[2],
                        req_ch == kvlt_pkg::MID_WORD[1],
                        req_ch == kvlt_pkg::MID_WORD[0]};
   end

   assign req_full = (count_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = link_pop && (count_ff != 2'd0);

   assign link.valid = (count_ff != 2'd0);
   assign link.cls   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cls_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("front queue count out of range");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_full && !pop_ok) |=> req_full)
      else $error("front queue left full state without a pop");

   a_empty_holds: assert property (@(posedge clock) disable iff (reset)
      (!link.valid && !req_push) |=> !link.valid)
      else $error("front queue became valid without a push");
`endif

endmodule

[sv/kvlt_back.sv]
// ----------------------------------------------------------------------------
// kvlt_back
// Token state machine, message id accumulator and two-entry result queue.
// ----------------------------------------------------------------------------
module kvlt_back (
   input  logic               clock,
   input  logic               reset,
   input  kvlt_pkg::link_type link,
   output logic               link_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output kvlt_pkg::rsp_type  rsp
);

   kvlt_pkg::phase_type        phase_ff, phase_in;
   logic [kvlt_pkg::SLOT_W-1:0] slot_ff, slot_in, slot_inc;
   logic [kvlt_pkg::SLOT_W+3:0] slot_wide, slot_in_wide;
   logic [2:0]                 mid_ff, mid_in, mid_base;
   logic [31:0]                acc_ff, acc_in, acc_b, acc10;
   logic [1:0]                 dph_ff, dph_in, dph_b;
   logic                       neg_ff, neg_in, neg_b;
   logic                       err_ff, err_in;
   logic [31:0]                held_ff, held_in;

   kvlt_pkg::rsp_type          q_ff [2];
   kvlt_pkg::rsp_type          rsp_in;
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 count_ff, count_in;

   kvlt_pkg::cls_type          c;
   logic                       take, out_pop;
   logic                       fin, valued, err_set, key_en, key_restart, mid_kill;
   logic                       val_start, id_en, is_mid;
   logic [1:0]                 role;
   logic                       start;

   assign c         = link.cls;
   assign take      = link.valid && (count_ff != 2'd2);
   assign link_pop  = take;
   assign out_pop   = rsp_pop && (count_ff != 2'd0);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp       = q_ff[rd_ptr_ff];

   // next state
   always_comb begin
      phase_in    = phase_ff;
      fin         = 1'b0;
      valued      = 1'b0;
      err_set     = 1'b0;
      key_en      = 1'b0;
      key_restart = 1'b0;
      mid_kill    = 1'b0;
      val_start   = 1'b0;
      id_en       = 1'b0;
      is_mid      = 1'b0;
      slot_inc    = slot_ff + 1'b1;
      unique case (phase_ff)
         kvlt_pkg::PH_BETWEEN: begin
            if (c.zero || c.space) begin
            end else if (c.eq) begin
               mid_kill  = 1'b1;
               val_start = 1'b1;
               phase_in  = kvlt_pkg::PH_AFTER_EQ;
            end else begin
               key_restart = 1'b1;
               val_start   = 1'b1;
               phase_in    = kvlt_pkg::PH_KEY;
            end
         end
         kvlt_pkg::PH_KEY: begin
            if (c.zero || c.space) begin
               fin = 1'b1;
            end else if (c.eq) begin
               phase_in = kvlt_pkg::PH_AFTER_EQ;
            end else begin
               key_en = 1'b1;
            end
         end
         kvlt_pkg::PH_AFTER_EQ: begin
            if (c.semi || c.space || c.zero) begin
               err_set = 1'b1;
            end else if (c.quote) begin
               phase_in = kvlt_pkg::PH_QOPEN;
            end else begin
               id_en    = 1'b1;
               phase_in = kvlt_pkg::PH_VAL;
            end
         end
         kvlt_pkg::PH_QOPEN: begin
            if (c.zero) begin
               err_set = 1'b1;
            end else if (c.quote) begin
               fin    = 1'b1;
               valued = 1'b1;
            end else begin
               id_en    = 1'b1;
               phase_in = kvlt_pkg::PH_QVAL;
            end
         end
         kvlt_pkg::PH_VAL: begin
            if (c.zero || c.space || c.eq) begin
               fin    = 1'b1;
               valued = 1'b1;
            end else begin
               id_en = 1'b1;
            end
         end
         kvlt_pkg::PH_QVAL: begin
            if (c.zero) begin
               err_set = 1'b1;
            end else if (c.quote) begin
               fin    = 1'b1;
               valued = 1'b1;
            end else begin
               id_en = 1'b1;
            end
         end
         default: begin
            err_set = 1'b1;
         end
      endcase
      if (fin) begin
         if (valued && (mid_ff == kvlt_pkg::MID_FULL)) begin
            is_mid   = 1'b1;
            phase_in = kvlt_pkg::PH_BETWEEN;
         end else if (slot_inc >= kvlt_pkg::SLOT_W'(kvlt_pkg::SLOT_LIMIT)) begin
            err_set = 1'b1;
         end else begin
            phase_in = kvlt_pkg::PH_BETWEEN;
         end
      end
      if (err_set) begin
         phase_in = kvlt_pkg::PH_ERROR;
      end
      if (c.zero) begin
         phase_in = kvlt_pkg::PH_BETWEEN;
      end
   end

   // outputs
   always_comb begin
      role  = kvlt_pkg::ROLE_SEP;
      start = 1'b0;
      unique case (phase_ff)
         kvlt_pkg::PH_BETWEEN: begin
            if (!(c.zero || c.space || c.eq)) begin
               role  = kvlt_pkg::ROLE_KEY;
               start = 1'b1;
            end
         end
         kvlt_pkg::PH_KEY: begin
            if (!(c.zero || c.space || c.eq)) begin
               role = kvlt_pkg::ROLE_KEY;
            end
         end
         kvlt_pkg::PH_AFTER_EQ: begin
            if (!(c.semi || c.space || c.zero || c.quote)) begin
               role  = kvlt_pkg::ROLE_VAL;
               start = 1'b1;
            end
         end
         kvlt_pkg::PH_QOPEN: begin
            if (!(c.zero || c.quote)) begin
               role  = kvlt_pkg::ROLE_VAL;
               start = 1'b1;
            end
         end
         kvlt_pkg::PH_VAL: begin
            if (!(c.zero || c.space || c.eq)) begin
               role = kvlt_pkg::ROLE_VAL;
            end
         end
         kvlt_pkg::PH_QVAL: begin
            if (!(c.zero || c.quote)) begin
               role = kvlt_pkg::ROLE_VAL;
            end
         end
         default: begin
            role  = kvlt_pkg::ROLE_SEP;
            start = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      mid_base = key_restart ? 3'd0 : mid_ff;
      mid_in   = mid_ff;
      if (key_en || key_restart) begin
         if ((mid_base < kvlt_pkg::MID_FULL) && c.mid_hit[mid_base[1:0]]) begin
            mid_in = mid_base + 3'd1;
         end else begin
            mid_in = kvlt_pkg::MID_MISS;
         end
      end
      if (mid_kill) begin
         mid_in = kvlt_pkg::MID_MISS;
      end

      acc_b  = val_start ? 32'd0 : acc_ff;
      dph_b  = val_start ? kvlt_pkg::DPH_LEAD : dph_ff;
      neg_b  = val_start ? 1'b0 : neg_ff;
      acc10  = (acc_b << 3) + (acc_b << 1) + {28'd0, c.dval};
      acc_in = acc_b;
      dph_in = dph_b;
      neg_in = neg_b;
      if (id_en) begin
         if (dph_b == kvlt_pkg::DPH_LEAD) begin
            if (c.ws) begin
            end else if (c.plus || c.minus) begin
               neg_in = c.minus;
               dph_in = kvlt_pkg::DPH_DIG;
            end else if (c.digit) begin
               dph_in = kvlt_pkg::DPH_DIG;
               acc_in = acc10;
            end else begin
               dph_in = kvlt_pkg::DPH_STOP;
            end
         end else if (dph_b == kvlt_pkg::DPH_DIG) begin
            if (c.digit) begin
               acc_in = acc10;
            end else begin
               dph_in = kvlt_pkg::DPH_STOP;
            end
         end
      end

      held_in = held_ff;
      if (is_mid) begin
         held_in = neg_ff ? (32'd0 - acc_ff) : acc_ff;
      end
      slot_in      = (fin && !is_mid) ? slot_inc : slot_ff;
      err_in       = err_ff || err_set;
      slot_wide    = {4'd0, slot_ff};
      slot_in_wide = {4'd0, slot_in};

      rsp_in.role        = role;
      rsp_in.slot        = (role != kvlt_pkg::ROLE_SEP) ? slot_wide[3:0] : 4'd0;
      rsp_in.token_start = start;
      rsp_in.retract     = is_mid;
      rsp_in.line_done   = c.zero;
      rsp_in.parse_error = err_in;
      rsp_in.param_count = (c.zero && !err_in) ? slot_in_wide[3:0] : 4'd0;
      rsp_in.message_id  = held_in;

      wr_ptr_in = take ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = out_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, take} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= kvlt_pkg::PH_BETWEEN;
         slot_ff   <= '0;
         mid_ff    <= 3'd0;
         acc_ff    <= 32'd0;
         dph_ff    <= kvlt_pkg::DPH_LEAD;
         neg_ff    <= 1'b0;
         err_ff    <= 1'b0;
         held_ff   <= 32'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (take) begin
            phase_ff <= phase_in;
            if (c.zero) begin
               slot_ff <= '0;
               mid_ff  <= 3'd0;
               acc_ff  <= 32'd0;
               dph_ff  <= kvlt_pkg::DPH_LEAD;
               neg_ff  <= 1'b0;
               err_ff  <= 1'b0;
               held_ff <= 32'd0;
            end else begin
               slot_ff <= slot_in;
               mid_ff  <= mid_in;
               acc_ff  <= acc_in;
               dph_ff  <= dph_in;
               neg_ff  <= neg_in;
               err_ff  <= err_in;
               held_ff <= held_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wr_ptr_ff] <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_line_clears: assert property (@(posedge clock) disable iff (reset)
      (take && c.zero) |=> (phase_ff == kvlt_pkg::PH_BETWEEN) && !err_ff && (slot_ff == '0))
      else $error("state not cleared after end of line");

   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == kvlt_pkg::PH_ERROR) |-> err_ff)
      else $error("error phase without error flag");

   a_slot_limit: assert property (@(posedge clock) disable iff (reset)
      !err_ff |-> (slot_ff < kvlt_pkg::SLOT_W'(kvlt_pkg::SLOT_LIMIT)))
      else $error("slot count at limit without error");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");
`endif

endmodule
